// ===== rtl/core/gfan_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfan_pkg
// Shared constants, stage payload types and the fan ring table for the
// terrain patch fan triangulation core.
// ----------------------------------------------------------------------------
package gfan_pkg;

   // Patch geometry and map limits
   localparam int PATCH_SIZE     = 17;
   localparam int SPAN           = PATCH_SIZE - 1;
   localparam int SPAN_SHIFT     = $clog2(SPAN);
   localparam int MAX_MAP_SIZE   = 4097;
   localparam int MAP_SIZE_RESET = 257;

   // Field widths
   localparam int MS_W    = 13;
   localparam int COORD_W = 13;
   localparam int IDX_W   = 25;
   localparam int PATCH_W = 8;
   localparam int FAN_W   = 3;
   localparam int LVL_W   = 2;
   localparam int OFS_W   = SPAN_SHIFT;
   localparam int PROD_W  = COORD_W + MS_W;

   // Stream payload widths (padded to whole bytes)
   localparam int REQ_W = 32;
   localparam int RSP_W = 80;

   // Row and column picks around the fan centre
   typedef enum logic [1:0] {ROW_UP, ROW_MID, ROW_DN} row_sel_type;
   typedef enum logic [1:0] {COL_LEFT, COL_MID, COL_RIGHT} col_sel_type;

   typedef struct packed {
      row_sel_type row;
      col_sel_type col;
   } vertex_sel_type;

   // Stage 1: fan centre and side splits
   typedef struct packed {
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] x;
      logic [LVL_W-1:0]   lvl;
      logic [3:0]         split;
      logic [MS_W-1:0]    ms;
   } stage1_type;

   // Stage 2: centre row base and half-step row stride
   typedef struct packed {
      logic [IDX_W-1:0]   prod;
      logic [IDX_W-1:0]   hms;
      logic [COORD_W-1:0] x;
      logic [LVL_W-1:0]   lvl;
      logic [3:0]         split;
   } stage2_type;

   // Stage 3: three row bases and three columns
   typedef struct packed {
      logic [IDX_W-1:0]   rb_up;
      logic [IDX_W-1:0]   rb_mid;
      logic [IDX_W-1:0]   rb_dn;
      logic [COORD_W-1:0] col_l;
      logic [COORD_W-1:0] col_c;
      logic [COORD_W-1:0] col_r;
      logic [3:0]         split;
   } stage3_type;

   // Perimeter ring, clockwise from lower left:
   // lower left, left, upper left, up, upper right, right, lower right, down
   function automatic vertex_sel_type ring_vertex(input logic [2:0] j);
      vertex_sel_type v;
      unique case (j)
         3'd0: v = '{row: ROW_DN,  col: COL_LEFT};
         3'd1: v = '{row: ROW_MID, col: COL_LEFT};
         3'd2: v = '{row: ROW_UP,  col: COL_LEFT};
         3'd3: v = '{row: ROW_UP,  col: COL_MID};
         3'd4: v = '{row: ROW_UP,  col: COL_RIGHT};
         3'd5: v = '{row: ROW_MID, col: COL_RIGHT};
         3'd6: v = '{row: ROW_DN,  col: COL_RIGHT};
         3'd7: v = '{row: ROW_DN,  col: COL_MID};
         default: v = '{row: ROW_MID, col: COL_MID};
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/geomipmap_fan_triangulation_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// geomipmap_fan_triangulation_core
// Turns one fan request into its 4 to 8 triangles of heightmap vertex indices.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_tvalid/req_tready  | req_tdata (32b): one fan
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata (80b), rsp_tlast
//  csr     | in        | csr_valid/csr_ready    | csr_data (13b): map_size
//
//  One triangle leaves per cycle while rsp_tready is high; a fan has 4 plus
//  one per split side. The emitter sets the pace; three pipeline stages (fan
//  centre, row multiply, row bases) keep it fed, and a fan's first triangle
//  passes them, the emitter and the output register before rsp_tvalid rises.
//  Reset clears all valid bits and sets map_size to 257. A low rsp_tready holds
//  the output register and backs the stages up; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module geomipmap_fan_triangulation_core (
   input  wire                          clock,
   input  wire                          reset,
   // patch_row, patch_col, fan_row, fan_col, level, left_coarser,
   // top_coarser, right_coarser, bottom_coarser, zero pad
   input  wire  [gfan_pkg::REQ_W-1:0]   req_tdata,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // index_a, index_b, index_c, zero pad
   output logic [gfan_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire  [gfan_pkg::MS_W-1:0]    csr_data,
   input  wire                          csr_valid,
   output logic                         csr_ready
);

   localparam int IW = gfan_pkg::IDX_W;
   localparam int CW = gfan_pkg::COORD_W;
   localparam int MW = gfan_pkg::MS_W;
   localparam int PW = gfan_pkg::PATCH_W;
   localparam int FW = gfan_pkg::FAN_W;
   localparam int OW = gfan_pkg::OFS_W;

   // ---------------------------------------------------------------- config
   logic [MW-1:0] map_size_ff;

   assign csr_ready = 1'b1;

   // Hold map size; take each write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff <= MW'(gfan_pkg::MAP_SIZE_RESET);
      end else if (csr_valid && csr_ready) begin
         map_size_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------ flow control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, e_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready;
   logic out_free, e_fire, e_last, e_load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign e_fire     = e_valid_ff && out_free;
   assign e_load     = !e_valid_ff || (e_fire && e_last);
   assign s3_ready   = !s3_valid_ff || e_load;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // ------------------------------------------------------ stage 1: fan centre
   logic [MW-1:0]    ms_clamp, ms_m1;
   logic [MW-OW-1:0] pcount;
   logic [PW-1:0]    pmax, prow, pcol, prow_raw, pcol_raw;
   logic [FW-1:0]    fmask, frow, fcol;
   logic [1:0]       lvl;
   logic [OW-1:0]    half4, m_ofs, n_ofs;
   gfan_pkg::stage1_type s1_in, s1_ff;

   assign prow_raw = req_tdata[7:0];
   assign pcol_raw = req_tdata[15:8];
   assign lvl      = req_tdata[23:22];

   always_comb begin
      // Clamp map size and find the last patch per side
      if (map_size_ff < MW'(gfan_pkg::PATCH_SIZE)) begin
         ms_clamp = MW'(gfan_pkg::PATCH_SIZE);
      end else if (map_size_ff > MW'(gfan_pkg::MAX_MAP_SIZE)) begin
         ms_clamp = MW'(gfan_pkg::MAX_MAP_SIZE);
      end else begin
         ms_clamp = map_size_ff;
      end
      ms_m1  = ms_clamp - MW'(1);
      pcount = ms_m1[MW-1:OW];
      pmax   = PW'(pcount - (MW-OW)'(1));

      prow = (prow_raw > pmax) ? pmax : prow_raw;
      pcol = (pcol_raw > pmax) ? pmax : pcol_raw;

      // Wrap fan indices to the fans per side
      fmask = FW'(3'b111 >> lvl);
      frow  = req_tdata[18:16] & fmask;
      fcol  = req_tdata[21:19] & fmask;

      half4 = OW'(1) << lvl;
      m_ofs = OW'({1'b0, frow} << (3'(lvl) + 3'd1)) | half4;
      n_ofs = OW'({1'b0, fcol} << (3'(lvl) + 3'd1)) | half4;

      s1_in.z   = CW'({prow, m_ofs});
      s1_in.x   = CW'({pcol, n_ofs});
      s1_in.lvl = lvl;
      s1_in.ms  = ms_clamp;

      // Keep a side split unless it meets a coarser inner neighbor
      s1_in.split[0] = !((fcol == '0)    && (pcol != '0)   && req_tdata[24]);
      s1_in.split[1] = !((frow == '0)    && (prow != '0)   && req_tdata[25]);
      s1_in.split[2] = !((fcol == fmask) && (pcol != pmax) && req_tdata[26]);
      s1_in.split[3] = !((frow == fmask) && (prow != pmax) && req_tdata[27]);
   end

   // Advance stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------- stage 2: row multiply
   logic [gfan_pkg::PROD_W-1:0] prod_full;
   gfan_pkg::stage2_type s2_in, s2_ff;

   always_comb begin
      prod_full   = {{(gfan_pkg::PROD_W-CW){1'b0}}, s1_ff.z}
                  * {{(gfan_pkg::PROD_W-MW){1'b0}}, s1_ff.ms};
      s2_in.prod  = prod_full[IW-1:0];
      s2_in.hms   = IW'({{(IW-MW){1'b0}}, s1_ff.ms} << s1_ff.lvl);
      s2_in.x     = s1_ff.x;
      s2_in.lvl   = s1_ff.lvl;
      s2_in.split = s1_ff.split;
   end

   // Advance stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   // ----------------------------------------------------- stage 3: row bases
   logic [CW-1:0] half13;
   gfan_pkg::stage3_type s3_in, s3_ff;

   always_comb begin
      half13       = CW'(1) << s2_ff.lvl;
      s3_in.rb_up  = s2_ff.prod - s2_ff.hms;
      s3_in.rb_mid = s2_ff.prod;
      s3_in.rb_dn  = s2_ff.prod + s2_ff.hms;
      s3_in.col_l  = s2_ff.x - half13;
      s3_in.col_c  = s2_ff.x;
      s3_in.col_r  = s2_ff.x + half13;
      s3_in.split  = s2_ff.split;
   end

   // Advance stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
   end

   // --------------------------------------------------------- triangle emitter
   gfan_pkg::stage3_type e_ff;
   logic [1:0] side_ff;
   logic       half_ff;
   logic       cur_split;
   logic [2:0] b_pos, c_pos;
   logic [IW-1:0] idx_a, idx_b, idx_c;

   function automatic logic [IW-1:0] vertex_index(input gfan_pkg::stage3_type f,
                                                  input logic [2:0] j);
      gfan_pkg::vertex_sel_type v;
      logic [IW-1:0] rb;
      logic [CW-1:0] col;
      v = gfan_pkg::ring_vertex(j);
      unique case (v.row)
         gfan_pkg::ROW_UP:  rb = f.rb_up;
         gfan_pkg::ROW_MID: rb = f.rb_mid;
         gfan_pkg::ROW_DN:  rb = f.rb_dn;
         default:           rb = f.rb_mid;
      endcase
      unique case (v.col)
         gfan_pkg::COL_LEFT:  col = f.col_l;
         gfan_pkg::COL_MID:   col = f.col_c;
         gfan_pkg::COL_RIGHT: col = f.col_r;
         default:             col = f.col_c;
      endcase
      return rb + IW'(col);
   endfunction

   always_comb begin
      cur_split = e_ff.split[side_ff];
      e_last    = (side_ff == 2'd3) && (!cur_split || half_ff);
      // Split side: outer then inner half; unsplit: corner to corner
      b_pos = {side_ff, 1'b0} + 3'(cur_split && half_ff);
      c_pos = (cur_split && !half_ff) ? {side_ff, 1'b1} : ({side_ff, 1'b0} + 3'd2);
      idx_a = e_ff.rb_mid + IW'(e_ff.col_c);
      idx_b = vertex_index(e_ff, b_pos);
      idx_c = vertex_index(e_ff, c_pos);
   end

   // Load a new fan or step through the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         side_ff    <= 2'd0;
         half_ff    <= 1'b0;
      end else if (e_load) begin
         e_valid_ff <= s3_valid_ff;
         side_ff    <= 2'd0;
         half_ff    <= 1'b0;
      end else if (e_fire) begin
         if (cur_split && !half_ff) begin
            half_ff <= 1'b1;
         end else begin
            side_ff <= side_ff + 2'd1;
            half_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_load) begin
         e_ff <= s3_ff;
      end
   end

   // --------------------------------------------------------- output register
   logic [gfan_pkg::RSP_W-1:0] rsp_data_in, rsp_data_ff;
   logic                       rsp_last_ff;

   assign rsp_data_in = {{(gfan_pkg::RSP_W - 3*IW){1'b0}}, idx_c, idx_b, idx_a};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (e_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (e_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/gfan_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfan_checker
// Port-level checks for the fan triangulation core, bound to the top level.
// ----------------------------------------------------------------------------
module gfan_checker (
   input wire                         clock,
   input wire                         reset,
   input wire [gfan_pkg::REQ_W-1:0]   req_tdata,
   input wire                         req_tvalid,
   input wire                         req_tready,
   input wire [gfan_pkg::RSP_W-1:0]   rsp_tdata,
   input wire                         rsp_tlast,
   input wire                         rsp_tvalid,
   input wire                         rsp_tready,
   input wire [gfan_pkg::MS_W-1:0]    csr_data,
   input wire                         csr_valid,
   input wire                         csr_ready
);

   localparam int IW = gfan_pkg::IDX_W;

   logic       req_fire, rsp_fire;
   logic [2:0] pending_ff, pending_in;
   logic       in_fan_ff;
   logic [IW-1:0] centre_ff;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff + 3'(req_fire) - 3'(rsp_fire && rsp_tlast);
   end

   // Track fans in flight and the centre of the fan being delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
         in_fan_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_fire) begin
            in_fan_ff <= !rsp_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         centre_ff <= rsp_tdata[IW-1:0];
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Configuration is always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

   // No triangle without a fan in flight
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 3'd0)
      else $error("triangle without a pending fan");

   // Pipeline holds at most five fans
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd5)
      else $error("too many fans in flight");

   // Every triangle of a fan shares its centre vertex
   a_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && in_fan_ff |-> rsp_tdata[IW-1:0] == centre_ff)
      else $error("fan centre changed within a fan");

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_data};

endmodule

bind geomipmap_fan_triangulation_core gfan_checker u_gfan_checker (.*);
`default_nettype wire

// ===== test/geomipmap_fan_triangulation_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geomipmap_fan_triangulation_core_test
// Streams fan requests into the triangulation core under random backpressure
// and checks every triangle against an in-bench prediction of the vertex
// indices. The map size register is stepped through reset, clamped, uneven
// and random values between quiet phases.
// ----------------------------------------------------------------------------
module geomipmap_fan_triangulation_core_test;

   localparam int  SPAN          = gfan_pkg::PATCH_SIZE - 1;
   localparam int  SETTLE_CYCLES = 24;
   localparam int  LONG_HOLD     = 300;
   localparam int  HOLD_AFTER    = 250;
   localparam longint unsigned IDX_MASK = (64'd1 << gfan_pkg::IDX_W) - 1;

   typedef struct {
      logic [7:0] patch_row;
      logic [7:0] patch_col;
      logic [2:0] fan_row;
      logic [2:0] fan_col;
      logic [1:0] level;
      logic       left_coarser;
      logic       top_coarser;
      logic       right_coarser;
      logic       bottom_coarser;
   } fan_req_type;

   typedef struct {
      logic [gfan_pkg::IDX_W-1:0] index_a;
      logic [gfan_pkg::IDX_W-1:0] index_b;
      logic [gfan_pkg::IDX_W-1:0] index_c;
      logic                       last;
   } fan_tri_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic [gfan_pkg::REQ_W-1:0]   req_tdata = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [gfan_pkg::RSP_W-1:0]   rsp_tdata;
   logic                         rsp_tlast;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [gfan_pkg::MS_W-1:0]    csr_data = '0;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;

   fan_req_type fan_pending_q[$];
   fan_tri_type tri_expect_q[$];
   fan_tri_type fan_tris[8];
   int          fan_tri_n;

   logic [gfan_pkg::MS_W-1:0] map_size_cfg =
      gfan_pkg::MAP_SIZE_RESET[gfan_pkg::MS_W-1:0];

   int errors       = 0;
   int fans_sent    = 0;
   int tris_seen    = 0;
   int map_settings = 1;

   geomipmap_fan_triangulation_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Effective map size after clamping to the supported range
   function automatic longint unsigned eff_map_size();
      longint unsigned ms;
      ms = map_size_cfg;
      if (ms < gfan_pkg::PATCH_SIZE) ms = gfan_pkg::PATCH_SIZE;
      if (ms > gfan_pkg::MAX_MAP_SIZE) ms = gfan_pkg::MAX_MAP_SIZE;
      return ms;
   endfunction

   function automatic logic [gfan_pkg::IDX_W-1:0] vertex_index(
         input longint unsigned r, input longint unsigned c, input longint unsigned ms);
      longint unsigned v;
      v = (r * ms + c) & IDX_MASK;
      return v[gfan_pkg::IDX_W-1:0];
   endfunction

   // Append one side: two triangles when split, one otherwise
   function automatic void add_side(input bit split, input logic [gfan_pkg::IDX_W-1:0] ctr,
         input logic [gfan_pkg::IDX_W-1:0] p1, input logic [gfan_pkg::IDX_W-1:0] mid,
         input logic [gfan_pkg::IDX_W-1:0] p2);
      if (split) begin
         fan_tris[fan_tri_n]     = '{ctr, p1, mid, 1'b0};
         fan_tris[fan_tri_n + 1] = '{ctr, mid, p2, 1'b0};
         fan_tri_n += 2;
      end else begin
         fan_tris[fan_tri_n] = '{ctr, p1, p2, 1'b0};
         fan_tri_n += 1;
      end
   endfunction

   // Work out the triangles of one fan and queue them as expected
   function automatic void predict_fan_triangles(input fan_req_type f);
      longint unsigned ms, pcount, prow, pcol, half, fans, m, n, z, x;
      logic [gfan_pkg::IDX_W-1:0] ctr;
      bit sl, st, sr, sb;
      ms     = eff_map_size();
      pcount = (ms - 1) / SPAN;
      prow   = (f.patch_row > pcount - 1) ? pcount - 1 : f.patch_row;
      pcol   = (f.patch_col > pcount - 1) ? pcount - 1 : f.patch_col;
      half   = 64'd1 << f.level;
      fans   = SPAN >> (f.level + 1);
      if (fans == 0) return;
      m = half + (f.fan_row % fans) * 2 * half;
      n = half + (f.fan_col % fans) * 2 * half;
      sl = !((n == half) && pcol != 0 && f.left_coarser);
      st = !((m == half) && prow != 0 && f.top_coarser);
      sr = !((n >= SPAN - half) && pcol != pcount - 1 && f.right_coarser);
      sb = !((m >= SPAN - half) && prow != pcount - 1 && f.bottom_coarser);
      z = prow * SPAN + m;
      x = pcol * SPAN + n;
      ctr = vertex_index(z, x, ms);
      fan_tri_n = 0;
      add_side(sl, ctr, vertex_index(z + half, x - half, ms),
               vertex_index(z, x - half, ms), vertex_index(z - half, x - half, ms));
      add_side(st, ctr, vertex_index(z - half, x - half, ms),
               vertex_index(z - half, x, ms), vertex_index(z - half, x + half, ms));
      add_side(sr, ctr, vertex_index(z - half, x + half, ms),
               vertex_index(z, x + half, ms), vertex_index(z + half, x + half, ms));
      add_side(sb, ctr, vertex_index(z + half, x + half, ms),
               vertex_index(z + half, x, ms), vertex_index(z + half, x - half, ms));
      fan_tris[fan_tri_n - 1].last = 1'b1;
      for (int i = 0; i < fan_tri_n; i++)
         tri_expect_q = {tri_expect_q, fan_tris[i]};
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int next_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
         input longint unsigned want);
      $display("MISMATCH @%0t %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
   endtask

   // Request driver: hold each fan until its transfer, then gap or advance
   fan_req_type req_cur;
   int          req_gap   = 0;
   bit          req_burst = 1'b0;
   bit          req_busy;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         req_busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_fan_triangles(req_cur);
            fans_sent++;
            req_busy = 1'b0;
         end
         if ($urandom_range(0, 99) == 0) req_burst = !req_burst;
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (fan_pending_q.size() > 0) begin
               req_cur  = fan_pending_q.pop_front();
               req_busy = 1'b1;
               req_gap  = next_gap(req_burst);
            end
         end
         req_tvalid <= req_busy;
         req_tdata  <= {4'b0, req_cur.bottom_coarser, req_cur.right_coarser,
                        req_cur.top_coarser, req_cur.left_coarser, req_cur.level,
                        req_cur.fan_col, req_cur.fan_row, req_cur.patch_col,
                        req_cur.patch_row};
      end
   end

   // Triangle monitor: check each transfer, then pick the next ready
   fan_tri_type want;
   int          rsp_gap   = 0;
   int          long_hold = 0;
   bit          hold_done = 1'b0;
   bit          rsp_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            tris_seen++;
            if (tri_expect_q.size() == 0) begin
               report_mismatch("triangle with nothing expected",
                               rsp_tdata[gfan_pkg::IDX_W-1:0], 0);
            end else begin
               want = tri_expect_q.pop_front();
               if (rsp_tdata[24:0] !== want.index_a)
                  report_mismatch("index_a", rsp_tdata[24:0], want.index_a);
               if (rsp_tdata[49:25] !== want.index_b)
                  report_mismatch("index_b", rsp_tdata[49:25], want.index_b);
               if (rsp_tdata[74:50] !== want.index_c)
                  report_mismatch("index_c", rsp_tdata[74:50], want.index_c);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", rsp_tlast, want.last);
            end
            rsp_gap = next_gap(rsp_burst);
         end
         if ($urandom_range(0, 99) == 0) rsp_burst = !rsp_burst;
         // one long hold-off so the pipeline fills and stalls its input
         if (!hold_done && tris_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            long_hold = LONG_HOLD;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic add_fan(input int prow, input int pcol, input int frow, input int fcol,
         input int lvl, input bit l, input bit t, input bit r, input bit b);
      fan_req_type f;
      f = '{prow[7:0], pcol[7:0], frow[2:0], fcol[2:0], lvl[1:0], l, t, r, b};
      fan_pending_q = {fan_pending_q, f};
   endtask

   // Mostly in-grid fans with random content, some out-of-range noise
   task automatic add_random_fans(input int count);
      int pcount, lvl, fans;
      pcount = int'((eff_map_size() - 1) / SPAN);
      for (int i = 0; i < count; i++) begin
         lvl  = $urandom_range(0, 3);
         fans = SPAN >> (lvl + 1);
         add_fan(($urandom_range(0, 99) < 85) ? $urandom_range(0, pcount - 1)
                                              : $urandom_range(0, 255),
                 ($urandom_range(0, 99) < 85) ? $urandom_range(0, pcount - 1)
                                              : $urandom_range(0, 255),
                 ($urandom_range(0, 99) < 80) ? $urandom_range(0, fans - 1)
                                              : $urandom_range(0, 7),
                 ($urandom_range(0, 99) < 80) ? $urandom_range(0, fans - 1)
                                              : $urandom_range(0, 7),
                 lvl, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      end
   endtask

   // Sender pause: wait until every fan is out and every triangle is back
   task automatic wait_idle();
      do @(negedge clock);
      while (fan_pending_q.size() != 0 || req_tvalid || tri_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_map_size(input int value);
      @(posedge clock);
      csr_data  <= value[gfan_pkg::MS_W-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      map_size_cfg = value[gfan_pkg::MS_W-1:0];
      csr_valid <= 1'b0;
      map_settings++;
   endtask

   // Stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed fans at the reset map size (16 x 16 patches)
      add_fan(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_fan(0, 0, 0, 0, 0, 1, 1, 1, 1);
      add_fan(5, 5, 0, 0, 0, 1, 1, 1, 1);
      add_fan(5, 5, 7, 7, 0, 1, 1, 1, 1);
      add_fan(5, 5, 3, 3, 1, 1, 1, 1, 1);
      add_fan(5, 5, 1, 0, 2, 1, 1, 1, 1);
      add_fan(5, 5, 0, 0, 3, 1, 1, 1, 1);
      add_fan(5, 5, 0, 0, 3, 1, 0, 0, 0);
      add_fan(5, 5, 0, 0, 3, 0, 1, 0, 0);
      add_fan(5, 5, 0, 0, 3, 0, 0, 1, 0);
      add_fan(5, 5, 0, 0, 3, 0, 0, 0, 1);
      add_fan(15, 15, 0, 0, 3, 1, 1, 1, 1);
      add_fan(255, 255, 7, 7, 0, 1, 1, 1, 1);
      add_fan(200, 3, 2, 5, 1, 1, 1, 1, 1);
      add_fan(5, 5, 7, 5, 2, 1, 1, 1, 1);
      add_fan(5, 5, 6, 7, 1, 0, 1, 0, 1);
      add_fan(255, 255, 7, 7, 3, 1, 1, 1, 1);
      add_fan(0, 255, 7, 0, 0, 0, 1, 1, 0);
      wait_idle();

      // Largest map: every patch index is in the grid; long hold lands here
      write_map_size(gfan_pkg::MAX_MAP_SIZE);
      add_random_fans(150);
      wait_idle();

      // Smallest map: a single patch, all sides on the map border
      write_map_size(gfan_pkg::PATCH_SIZE);
      add_random_fans(30);
      wait_idle();

      // Below range clamps up, all-ones clamps down
      write_map_size(0);
      add_random_fans(20);
      wait_idle();
      write_map_size((1 << gfan_pkg::MS_W) - 1);
      add_random_fans(30);
      wait_idle();

      // Uneven size keeps its own row stride
      write_map_size(100);
      add_random_fans(50);
      wait_idle();

      // Random well-formed sizes
      repeat (4) begin
         write_map_size(gfan_pkg::PATCH_SIZE + SPAN * $urandom_range(0, 255));
         add_random_fans(30);
         wait_idle();
      end

      if (tri_expect_q.size() != 0)
         report_mismatch("triangles never delivered", tri_expect_q.size(), 0);
      $display("Ran %0d fans giving %0d triangles over %0d map size settings,",
               fans_sent, tris_seen, map_settings);
      $display("with clamped, uneven and border cases under random backpressure.");
      if (errors == 0) begin
         $display("geomipmap_fan_triangulation_core verification clean");
      end else begin
         $display("geomipmap_fan_triangulation_core verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("geomipmap_fan_triangulation_core verification failed");
      $finish;
   end

endmodule
